// File: hw/rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg: shared definitions for the positional insert/delete list
// Command and status codes, field widths, and the control bundle that the
// list controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package plid_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 7;

  // Default list depth
  localparam int DEPTH_DEF = 64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Committed operation, broadcast to all cells
  typedef struct packed {
    logic append;
    logic insert;
    logic remove;
  } cell_ctl_t;

endpackage

// File: hw/rtl/plid_cell.sv
// ----------------------------------------------------------------------------
// plid_cell: one entry of the list
// Holds one value and, on a committed command, loads the new value, takes
// its lower neighbor's value (insert) or its upper neighbor's value (remove).
// Also drives its value onto the read bus when its index is addressed.
// ----------------------------------------------------------------------------
module plid_cell
  import plid_pkg::*;
#(
  parameter int CW  = 7,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic [CW-1:0]    pos,
  input  logic [CW-1:0]    count,
  input  logic [VAL_W-1:0] value,
  input  logic [VAL_W-1:0] from_lower,
  input  logic [VAL_W-1:0] from_upper,
  output logic [VAL_W-1:0] data,
  output logic [VAL_W-1:0] rd_data
);

  localparam logic [CW-1:0] ID = CW'(IDX);

  logic [VAL_W-1:0] data_next;

  // Pick this cell's next value
  always_comb begin
    data_next = data;
    if (ctl.append && (ID == count)) begin
      data_next = value;
    end else if (ctl.insert && (ID == pos)) begin
      data_next = value;
    end else if (ctl.insert && (ID > pos)) begin
      data_next = from_lower;
    end else if (ctl.remove && (ID >= pos)) begin
      data_next = from_upper;
    end
  end

  // Hold or advance the entry
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Drive the read bus when addressed
  assign rd_data = (ID == pos) ? data : '0;

endmodule

// File: hw/rtl/positional_insert_delete_list_unit.sv
// The result beat is registered and appears in the cycle after its command beat is accepted.
// Throughput: one command per cycle; every cell of the chain shifts in parallel.
// The input stalls only while a result beat waits unaccepted in the output register.
// Reset clears the entry count and the output valid; entry contents are left
// undefined and are never read before being written.
// ----------------------------------------------------------------------------
// positional_insert_delete_list_unit: ordered list with positional edits
// Keeps up to DEPTH signed values in a chain of cells. Commands append,
// insert at a position, remove at a position or read at a position, and each
// returns one result beat with read value, status and entry count.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_unit
  import plid_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      command,
  input  logic [POS_W-1:0]      position,
  input  logic [VAL_W-1:0]      value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      read_value,
  output logic [STAT_W-1:0]     status,
  output logic [CNT_OUT_W-1:0]  entry_count
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [CW-1:0]     pos_c;
  logic [CMPW-1:0]   pos_w;
  logic [CMPW-1:0]   cnt_w;
  logic              accept;
  logic              is_full;
  logic              past_end;
  logic              at_or_past_end;
  logic [STAT_W-1:0] stat_next;
  logic [VAL_W-1:0]  rd_next;
  logic [VAL_W-1:0]  rd_bus;
  cell_ctl_t         ctl;

  logic [VAL_W-1:0] cell_data [DEPTH];
  logic [VAL_W-1:0] cell_rd   [DEPTH];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Bounds checks on a common width
  assign pos_c          = CW'(position);
  assign pos_w          = CMPW'(position);
  assign cnt_w          = CMPW'(count);
  assign is_full        = (count == FULL_CNT);
  assign past_end       = (pos_w > cnt_w);
  assign at_or_past_end = (pos_w >= cnt_w);

  // Decode command into a committed operation and its result
  always_comb begin
    ctl        = '0;
    stat_next  = ST_DONE;
    count_next = count;
    rd_next    = '0;
    case (command)
      CMD_APPEND: begin
        if (is_full) begin
          stat_next = ST_FULL;
        end else begin
          ctl.append = accept;
          count_next = count + CW'(1);
        end
      end
      CMD_INSERT: begin
        if (past_end) begin
          stat_next = ST_RANGE;
        end else if (is_full) begin
          stat_next = ST_FULL;
        end else begin
          ctl.insert = accept;
          count_next = count + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (at_or_past_end) begin
          stat_next = ST_RANGE;
        end else begin
          ctl.remove = accept;
          count_next = count - CW'(1);
        end
      end
      default: begin
        if (at_or_past_end) begin
          stat_next = ST_RANGE;
        end else begin
          rd_next = rd_bus;
        end
      end
    endcase
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = value;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    plid_cell #(
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos_c),
      .count      (count),
      .value      (value),
      .from_lower (lower),
      .from_upper (upper),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // Merge the per-cell read outputs; only the addressed cell is nonzero
  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_bus = rd_bus | cell_rd[k];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= rd_next;
      status      <= stat_next;
      entry_count <= CNT_OUT_W'(count_next);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count exceeds depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.insert) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the list by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (rst)
    (accept && ctl.remove) |=> (count == $past(count) - CW'(1)))
    else $error("remove did not shrink the list by one");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL)) |-> (entry_count == CNT_OUT_W'(DEPTH)))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_DONE)) |-> (read_value == '0))
    else $error("nonzero read value on error");
`endif

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional insert/delete list unit
// A clocked driver sends command beats from a pending queue filled at time
// zero. A shadow list predicts every result beat, and a clocked monitor checks
// each field of each result beat against the oldest prediction. Both sides
// idle in short random bursts, and once the receiver holds off long enough to
// back the unit up.
// ----------------------------------------------------------------------------
module tb_top
  import plid_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH   = DEPTH_DEF;
  localparam int ITEM_TARGET  = 1750;
  localparam int QUIET_TAIL   = 200;
  localparam int HOLD_AFTER   = 500;
  localparam int HOLD_CYCLES  = 200;
  localparam int STUCK_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;

  // Random segment flavors
  localparam int SEG_GROW   = 0;
  localparam int SEG_SHRINK = 1;
  localparam int SEG_MIXED  = 2;
  localparam int SEG_NOISE  = 3;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_cmd_t;

  typedef struct {
    logic [VAL_W-1:0]     rd;
    logic [STAT_W-1:0]    st;
    logic [CNT_OUT_W-1:0] cnt;
  } list_result_t;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic [CMD_W-1:0]     command     = '0;
  logic [POS_W-1:0]     position    = '0;
  logic [VAL_W-1:0]     value       = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [VAL_W-1:0]     read_value;
  logic [STAT_W-1:0]    status;
  logic [CNT_OUT_W-1:0] entry_count;

  list_cmd_t    pending_q[$];
  list_result_t result_q[$];

  // Shadow list used for prediction
  logic [VAL_W-1:0] shadow_mem[LIST_DEPTH];
  int               shadow_len = 0;

  // Entry count as the stimulus generator sees it
  int gen_len     = 0;
  int total_items = 0;
  int err_count   = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  positional_insert_delete_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .position   (position),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value),
    .status     (status),
    .entry_count(entry_count)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one command to the shadow list and queue the result it predicts
  task automatic predict_list_cmd(input list_cmd_t c);
    list_result_t r;
    int           p;
    r.rd = '0;
    r.st = ST_DONE;
    p = c.pos;
    case (c.cmd)
      CMD_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          shadow_mem[shadow_len] = c.val;
          shadow_len++;
        end
      end
      CMD_INSERT: begin
        if (p > shadow_len) begin
          r.st = ST_RANGE;
        end else if (shadow_len >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          for (int i = shadow_len; i > p; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[p] = c.val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (p >= shadow_len) begin
          r.st = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < shadow_len; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (p >= shadow_len) r.st = ST_RANGE;
        else r.rd = shadow_mem[p];
      end
    endcase
    r.cnt = shadow_len[CNT_OUT_W-1:0];
    result_q.push_back(r);
  endtask

  // Queue one command and track the entry count it leaves
  function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                                    logic [VAL_W-1:0] val);
    list_cmd_t c;
    c.cmd = cmd;
    c.pos = pos;
    c.val = val;
    pending_q.push_back(c);
    case (cmd)
      CMD_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      CMD_INSERT: if (pos <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      CMD_REMOVE: if (pos < gen_len) gen_len--;
      default: ;
    endcase
  endfunction

  // Pick a position for insert (slot) or remove/read (entry), in range or not
  function automatic logic [POS_W-1:0] pick_pos(bit for_insert, bit bad);
    int hi;
    hi = for_insert ? gen_len : gen_len - 1;
    if (hi > 63) hi = 63;
    if (bad) begin
      if (hi + 1 <= 63) return POS_W'($urandom_range(hi + 1, 63));
      return POS_W'($urandom);
    end
    if (hi < 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, hi));
  endfunction

  function automatic logic [VAL_W-1:0] pick_val();
    case ($urandom_range(0, 15))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Build the whole command stream before reset lifts
  initial begin : stimulus_gen
    int          kind;
    int          seg_len;
    int          roll;
    int          extra;
    bit          first_seg;
    logic [1:0]  cmd;

    // Directed: empty-list errors, value extremes, both insert ends, errors
    queue_cmd(CMD_READ,   6'd0,  32'h1234_5678);
    queue_cmd(CMD_REMOVE, 6'd0,  32'hFFFF_FFFF);
    queue_cmd(CMD_INSERT, 6'd1,  32'h0BAD_0BAD);
    queue_cmd(CMD_INSERT, 6'd0,  32'h7FFF_FFFF);
    queue_cmd(CMD_APPEND, 6'd63, 32'h8000_0000);
    queue_cmd(CMD_APPEND, 6'd0,  32'hFFFF_FFFF);
    queue_cmd(CMD_APPEND, 6'd42, 32'h0000_0000);
    queue_cmd(CMD_INSERT, 6'd4,  32'h5555_5555);
    queue_cmd(CMD_INSERT, 6'd1,  32'hAAAA_AAAA);
    queue_cmd(CMD_INSERT, 6'd7,  32'h0000_0001);
    queue_cmd(CMD_INSERT, 6'd63, 32'h0000_0002);
    queue_cmd(CMD_READ,   6'd0,  32'hFFFF_FFFF);
    queue_cmd(CMD_READ,   6'd5,  32'h0);
    queue_cmd(CMD_READ,   6'd6,  32'h0);
    queue_cmd(CMD_READ,   6'd63, 32'h0);
    queue_cmd(CMD_REMOVE, 6'd2,  32'h0);
    queue_cmd(CMD_REMOVE, 6'd4,  32'h0);
    queue_cmd(CMD_REMOVE, 6'd4,  32'h0);
    queue_cmd(CMD_REMOVE, 6'd63, 32'h0);
    queue_cmd(CMD_READ,   6'd1,  32'h0);
    queue_cmd(CMD_READ,   6'd3,  32'h0);
    queue_cmd(CMD_REMOVE, 6'd0,  32'h0);

    // Random: segments of growth, shrinkage, mixed traffic and noise
    first_seg = 1'b1;
    while (pending_q.size() < ITEM_TARGET) begin
      kind = first_seg ? SEG_GROW : $urandom_range(SEG_GROW, SEG_NOISE);
      first_seg = 1'b0;
      case (kind)
        SEG_GROW: begin
          // Fill to capacity, then push against the full list
          extra = $urandom_range(3, 10);
          while (gen_len < LIST_DEPTH || extra > 0) begin
            if (gen_len >= LIST_DEPTH) extra--;
            roll = $urandom_range(0, 19);
            if (roll < 9)       queue_cmd(CMD_APPEND, POS_W'($urandom), pick_val());
            else if (roll < 17) queue_cmd(CMD_INSERT, pick_pos(1, 0), pick_val());
            else if (roll < 18) queue_cmd(CMD_READ, pick_pos(0, 0), $urandom);
            else if (roll < 19) queue_cmd(CMD_REMOVE, pick_pos(0, 0), $urandom);
            else                queue_cmd(CMD_INSERT, pick_pos(1, 1), pick_val());
          end
        end
        SEG_SHRINK: begin
          // Drain toward empty, then poke the empty list
          extra = $urandom_range(2, 6);
          while (gen_len > 0 || extra > 0) begin
            if (gen_len == 0) extra--;
            roll = $urandom_range(0, 9);
            if (roll < 6)      queue_cmd(CMD_REMOVE, pick_pos(0, 0), $urandom);
            else if (roll < 8) queue_cmd(CMD_READ, pick_pos(0, 0), $urandom);
            else if (roll < 9) queue_cmd(CMD_REMOVE, pick_pos(0, 1), $urandom);
            else               queue_cmd(CMD_APPEND, POS_W'($urandom), pick_val());
          end
        end
        SEG_MIXED: begin
          seg_len = $urandom_range(30, 120);
          repeat (seg_len) begin
            cmd = 2'($urandom_range(0, 3));
            queue_cmd(cmd, pick_pos(cmd == CMD_INSERT, $urandom_range(0, 9) == 0),
                      pick_val());
          end
        end
        default: begin
          seg_len = $urandom_range(5, 15);
          repeat (seg_len) queue_cmd(2'($urandom), POS_W'($urandom), $urandom);
        end
      endcase
    end
    total_items = pending_q.size();
  end

  // Driver: offer beats from the pending queue, idling in short bursts
  int drv_gap  = 0;
  int drv_rate = 0;
  int drv_sent = 0;

  always @(posedge clk) begin
    list_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        c.cmd = command;
        c.pos = position;
        c.val = value;
        predict_list_cmd(c);
        drv_sent++;
        if (drv_sent % 100 == 0) drv_rate = $urandom_range(0, 3);
      end
      // Load the next beat only once the current one has gone
      if (!in_valid || !in_stall) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_q.size() > QUIET_TAIL && drv_rate != 0 &&
                     $urandom_range(0, 7) < drv_rate) begin
          drv_gap = $urandom_range(1, 3) - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          c = pending_q.pop_front();
          command  <= c.cmd;
          position <= c.pos;
          value    <= c.val;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts and one long hold-off to back the unit up
  int rx_seen   = 0;
  int rx_gap    = 0;
  int rx_rate   = 1;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (out_fire) begin
      rx_seen++;
      if (rx_seen % 100 == 0) rx_rate = $urandom_range(0, 3);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && rx_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_seen + QUIET_TAIL >= total_items) begin
      out_stall <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else if (rx_rate != 0 && $urandom_range(0, 7) < rx_rate) begin
      rx_gap = $urandom_range(1, 3) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_fire) begin
      if (result_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result beat rd=%h st=%0d cnt=%0d",
                 $realtime, read_value, status, entry_count);
      end else begin
        want = result_q.pop_front();
        if (read_value !== want.rd) begin
          err_count++;
          $display("%0t: read_value expected %h actual %h",
                   $realtime, want.rd, read_value);
        end
        if (status !== want.st) begin
          err_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.st, status);
        end
        if (entry_count !== want.cnt) begin
          err_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $realtime, want.cnt, entry_count);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (rst || in_fire || out_fire) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $realtime, STUCK_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Finish once every command is sent and every result has been checked
  initial begin
    @(negedge clk);
    while (rst || pending_q.size() != 0 || in_valid) @(negedge clk);
    while (result_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/plid_pkg.sv
hw/rtl/plid_cell.sv
hw/rtl/positional_insert_delete_list_unit.sv
verif/tb_top.sv
